[rtl/nmp_pkg.sv]
// Shared types, constants and the byte decode table for the normal perturb block.
// No dependencies; imported by every module of the block.
package nmp_pkg;

  localparam int ONE_Q14    = 16384;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;
  localparam int SQ_RW      = 35;
  localparam int DV_RW      = 48;

  // One summed vector passed from front to back
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic               degen;
  } nmp_item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } nmp_qstat_t;

  typedef logic signed [15:0] dec_tab_t [256];

  // round((2b-255)*16384/255), halves away from zero; built at elaboration
  function automatic dec_tab_t build_dec_tab();
    dec_tab_t tab;
    int t;
    int mag;
    int d;
    for (int b = 0; b < 256; b++) begin
      t = 2 * b - 255;
      mag = (t < 0 ? -t : t) * ONE_Q14;
      d = (2 * mag + 255) / 510;
      tab[b] = 16'(t < 0 ? -d : d);
    end
    return tab;
  endfunction

  localparam dec_tab_t DEC_TAB = build_dec_tab();

endpackage

[rtl/nmp_front.sv]
// Front end: texel decode, nine products, three sums and zero-length detect.
// Depends on nmp_pkg.
module nmp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           texel_byte0,
  input  logic [7:0]           texel_byte1,
  input  logic [7:0]           texel_byte2,
  input  logic signed [15:0]   tangent_x,
  input  logic signed [15:0]   tangent_y,
  input  logic signed [15:0]   tangent_z,
  input  logic signed [15:0]   bitangent_x,
  input  logic signed [15:0]   bitangent_y,
  input  logic signed [15:0]   bitangent_z,
  input  logic signed [15:0]   surface_normal_x,
  input  logic signed [15:0]   surface_normal_y,
  input  logic signed [15:0]   surface_normal_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nmp_pkg::nmp_item_t   out_item
);
  import nmp_pkg::*;

  logic               adv;
  logic signed [15:0] dx, dy, dz;
  logic               p_valid;
  logic signed [31:0] p [9];
  logic signed [33:0] sum_x, sum_y, sum_z;

  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  // decode, y flipped
  assign dx = DEC_TAB[texel_byte0];
  assign dy = -DEC_TAB[texel_byte1];
  assign dz = DEC_TAB[texel_byte2];

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p[0] <= tangent_x * dx;
      p[1] <= bitangent_x * dy;
      p[2] <= surface_normal_x * dz;
      p[3] <= tangent_y * dx;
      p[4] <= bitangent_y * dy;
      p[5] <= surface_normal_y * dz;
      p[6] <= tangent_z * dx;
      p[7] <= bitangent_z * dy;
      p[8] <= surface_normal_z * dz;
    end
  end

  // sum stage; magnitudes stay below 2^31
  assign sum_x = 34'(p[0]) + 34'(p[1]) + 34'(p[2]);
  assign sum_y = 34'(p[3]) + 34'(p[4]) + 34'(p[5]);
  assign sum_z = 34'(p[6]) + 34'(p[7]) + 34'(p[8]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.sx    <= sum_x[31:0];
      out_item.sy    <= sum_y[31:0];
      out_item.sz    <= sum_z[31:0];
      out_item.degen <= (sum_x == '0) && (sum_y == '0) && (sum_z == '0);
    end
  end

endmodule

[rtl/nmp_queue.sv]
// Short register queue between front and back.
// Depends on nmp_pkg.
module nmp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_stall,
  input  nmp_pkg::nmp_item_t   push_item,
  output logic                 pop_valid,
  input  logic                 pop_stall,
  output nmp_pkg::nmp_item_t   pop_item,
  output nmp_pkg::nmp_qstat_t  stat
);
  import nmp_pkg::*;

  nmp_item_t      mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           push, pop;

  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign push_stall = stat.full;
  assign pop_valid  = ~stat.empty;
  assign pop_item   = mem[rd_ptr];
  assign push       = push_valid & ~stat.full;
  assign pop        = pop_valid & ~pop_stall;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

endmodule

[rtl/nmp_back.sv]
// Back end: magnitude, normalize shift, squares, pipelined square root and
// three pipelined dividers. Depends on nmp_pkg.
module nmp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nmp_pkg::nmp_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   shaded_normal_x,
  output logic signed [15:0]   shaded_normal_y,
  output logic signed [15:0]   shaded_normal_z,
  output logic                 degenerate
);
  import nmp_pkg::*;

  function automatic logic [4:0] lead_zeros(input logic [30:0] v);
    logic [4:0] n;
    logic       found;
    n = '0;
    found = 1'b0;
    for (int b = 30; b >= 0; b--) begin
      if (!found) begin
        if (v[b]) found = 1'b1;
        else n = n + 5'd1;
      end
    end
    return n;
  endfunction

  logic adv;
  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  logic signed [31:0] s_in [3];
  assign s_in[0] = in_item.sx;
  assign s_in[1] = in_item.sy;
  assign s_in[2] = in_item.sz;

  // stage a: magnitudes and largest
  logic        a_valid, a_deg;
  logic [30:0] a_mag [3];
  logic [2:0]  a_neg;
  logic [30:0] a_max;
  logic [31:0] abs_v [3];
  logic [30:0] max01;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = s_in[i][31] ? (32'd0 - s_in[i]) : s_in[i];
    end
  end
  assign max01 = (abs_v[0][30:0] > abs_v[1][30:0]) ? abs_v[0][30:0] : abs_v[1][30:0];

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (adv) a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_mag[i] <= abs_v[i][30:0];
        a_neg[i] <= s_in[i][31];
      end
      a_max <= (max01 > abs_v[2][30:0]) ? max01 : abs_v[2][30:0];
      a_deg <= in_item.degen;
    end
  end

  // stage b: shift count
  logic        b_valid, b_deg;
  logic [30:0] b_mag [3];
  logic [2:0]  b_neg;
  logic [4:0]  b_k;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (adv) b_valid <= a_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mag <= a_mag;
      b_neg <= a_neg;
      b_deg <= a_deg;
      b_k   <= lead_zeros(a_max);
    end
  end

  // stage c: normalize
  logic        c_valid, c_deg;
  logic [30:0] c_mag [3];
  logic [2:0]  c_neg;

  always_ff @(posedge clk) begin
    if (rst) c_valid <= 1'b0;
    else if (adv) c_valid <= b_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) c_mag[i] <= b_mag[i] << b_k;
      c_neg <= b_neg;
      c_deg <= b_deg;
    end
  end

  // stage d: squares
  logic        d_valid, d_deg;
  logic [30:0] d_mag [3];
  logic [61:0] d_sq [3];
  logic [2:0]  d_neg;

  always_ff @(posedge clk) begin
    if (rst) d_valid <= 1'b0;
    else if (adv) d_valid <= c_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) d_sq[i] <= c_mag[i] * c_mag[i];
      d_mag <= c_mag;
      d_neg <= c_neg;
      d_deg <= c_deg;
    end
  end

  // square root pipeline, one result bit per stage; entry 0 is the sum stage
  logic [SQ_RW-1:0] sr_rem  [SQRT_STEPS+1];
  logic [31:0]      sr_root [SQRT_STEPS+1];
  logic [63:0]      sr_q    [SQRT_STEPS+1];
  logic [30:0]      sr_mag  [SQRT_STEPS+1][3];
  logic [2:0]       sr_neg  [SQRT_STEPS+1];
  logic             sr_deg  [SQRT_STEPS+1];
  logic             sr_valid[SQRT_STEPS+1];

  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) sr_valid[0] <= 1'b0;
    else if (adv) sr_valid[0] <= d_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_q[0]   <= 64'(d_sq[0]) + 64'(d_sq[1]) + 64'(d_sq[2]);
      sr_mag[0] <= d_mag;
      sr_neg[0] <= d_neg;
      sr_deg[0] <= d_deg;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [SQ_RW-1:0] cur, trial;
    assign cur   = {sr_rem[j][SQ_RW-3:0], sr_q[j][63-2*j -: 2]};
    assign trial = {1'b0, sr_root[j], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sr_valid[j+1] <= 1'b0;
      else if (adv) sr_valid[j+1] <= sr_valid[j];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cur >= trial) begin
          sr_rem[j+1]  <= cur - trial;
          sr_root[j+1] <= {sr_root[j][30:0], 1'b1};
        end else begin
          sr_rem[j+1]  <= cur;
          sr_root[j+1] <= {sr_root[j][30:0], 1'b0};
        end
        sr_q[j+1]   <= sr_q[j];
        sr_mag[j+1] <= sr_mag[j];
        sr_neg[j+1] <= sr_neg[j];
        sr_deg[j+1] <= sr_deg[j];
      end
    end
  end

  // dividers: (mag<<15 + L) / 2L, one quotient bit per stage
  logic [DV_RW-1:0]     dv_rem  [DIV_STEPS+1][3];
  logic [DIV_STEPS-1:0] dv_quo  [DIV_STEPS+1][3];
  logic [32:0]          dv_d    [DIV_STEPS+1];
  logic [2:0]           dv_neg  [DIV_STEPS+1];
  logic                 dv_deg  [DIV_STEPS+1];
  logic                 dv_valid[DIV_STEPS+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] = DV_RW'({sr_mag[SQRT_STEPS][i], 15'b0}) + DV_RW'(sr_root[SQRT_STEPS]);
      dv_quo[0][i] = '0;
    end
  end
  assign dv_d[0]     = {sr_root[SQRT_STEPS], 1'b0};
  assign dv_neg[0]   = sr_neg[SQRT_STEPS];
  assign dv_deg[0]   = sr_deg[SQRT_STEPS];
  assign dv_valid[0] = sr_valid[SQRT_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    logic [DV_RW-1:0] cmp;
    assign cmp = DV_RW'(dv_d[s]) << (DIV_STEPS - 1 - s);

    always_ff @(posedge clk) begin
      if (rst) dv_valid[s+1] <= 1'b0;
      else if (adv) dv_valid[s+1] <= dv_valid[s];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[s][i] >= cmp) begin
            dv_rem[s+1][i] <= dv_rem[s][i] - cmp;
            dv_quo[s+1][i] <= {dv_quo[s][i][DIV_STEPS-2:0], 1'b1};
          end else begin
            dv_rem[s+1][i] <= dv_rem[s][i];
            dv_quo[s+1][i] <= {dv_quo[s][i][DIV_STEPS-2:0], 1'b0};
          end
        end
        dv_d[s+1]   <= dv_d[s];
        dv_neg[s+1] <= dv_neg[s];
        dv_deg[s+1] <= dv_deg[s];
      end
    end
  end

  // output register: clamp, sign, zero on degenerate
  logic [15:0] o_mag [3];
  logic [15:0] o_val [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_mag[i] = (dv_quo[DIV_STEPS][i] > DIV_STEPS'(ONE_Q14)) ? 16'(ONE_Q14)
                                                             : 16'(dv_quo[DIV_STEPS][i]);
      if (dv_deg[DIV_STEPS]) o_val[i] = '0;
      else o_val[i] = dv_neg[DIV_STEPS][i] ? (16'd0 - o_mag[i]) : o_mag[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dv_valid[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      shaded_normal_x <= o_val[0];
      shaded_normal_y <= o_val[1];
      shaded_normal_z <= o_val[2];
      degenerate      <= dv_deg[DIV_STEPS];
    end
  end

endmodule

[rtl/normal_map_perturb.sv]
// Top level of the tangent-space normal perturb block: front, queue, back.
// Depends on nmp_pkg, nmp_front, nmp_queue, nmp_back.
//
//   channel | handshake           | beat contents
//   in      | in_valid, in_stall   | texel_byte0..2, tangent/bitangent/surface_normal xyz
//   out     | out_valid, out_stall | shaded_normal_x/y/z, degenerate
//
// One beat per cycle sustained while out_stall is low; the input-to-output delay is set by
// the 32-stage square root and the 15-stage dividers of the back end.
// Reset clears valid bits, queue pointers and fill count only; no clearing pass.
// Output stall freezes the back end; the front keeps filling the 4-deep
// queue and stalls the input only when the queue is full.
module normal_map_perturb (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         texel_byte0,
  input  logic [7:0]         texel_byte1,
  input  logic [7:0]         texel_byte2,
  input  logic signed [15:0] tangent_x,
  input  logic signed [15:0] tangent_y,
  input  logic signed [15:0] tangent_z,
  input  logic signed [15:0] bitangent_x,
  input  logic signed [15:0] bitangent_y,
  input  logic signed [15:0] bitangent_z,
  input  logic signed [15:0] surface_normal_x,
  input  logic signed [15:0] surface_normal_y,
  input  logic signed [15:0] surface_normal_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] shaded_normal_x,
  output logic signed [15:0] shaded_normal_y,
  output logic signed [15:0] shaded_normal_z,
  output logic               degenerate
);
  import nmp_pkg::*;

  logic       f_valid, f_stall, q_valid, q_stall;
  nmp_item_t  f_item, q_item;
  nmp_qstat_t q_stat;

  nmp_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .texel_byte0, .texel_byte1, .texel_byte2,
    .tangent_x, .tangent_y, .tangent_z,
    .bitangent_x, .bitangent_y, .bitangent_z,
    .surface_normal_x, .surface_normal_y, .surface_normal_z,
    .out_valid (f_valid),
    .out_stall (f_stall),
    .out_item  (f_item)
  );

  nmp_queue u_queue (
    .clk, .rst,
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_item   (q_item),
    .stat       (q_stat)
  );

  nmp_back u_back (
    .clk, .rst,
    .in_valid (q_valid),
    .in_stall (q_stall),
    .in_item  (q_item),
    .out_valid, .out_stall,
    .shaded_normal_x, .shaded_normal_y, .shaded_normal_z, .degenerate
  );

  // queue cannot be full and empty at once
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // degenerate beats carry a zero vector
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |->
      (shaded_normal_x == 16'sd0 && shaded_normal_y == 16'sd0 && shaded_normal_z == 16'sd0))
    else $error("degenerate beat with nonzero normal");

  // components stay within unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (shaded_normal_x <= 16'sd16384 && shaded_normal_x >= -16'sd16384 &&
       shaded_normal_y <= 16'sd16384 && shaded_normal_y >= -16'sd16384 &&
       shaded_normal_z <= 16'sd16384 && shaded_normal_z >= -16'sd16384))
    else $error("normal component out of range");

endmodule
